// ----- hdl/gbf_pkg.sv -----
// Shared constants and store entry types for the greedy best-fit block.
package gbf_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int MAX_BINS  = 1024;

  localparam int IIDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int BIDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int ICNT_W = $clog2(MAX_ITEMS + 1);
  localparam int BCNT_W = $clog2(MAX_BINS + 1);

  localparam int DATA_W  = 31;
  localparam int TOTAL_W = 41;
  localparam int PLACE_W = 11;

  localparam logic [1:0] OP_LOAD_ITEM = 2'd0;
  localparam logic [1:0] OP_LOAD_BIN  = 2'd1;
  localparam logic [1:0] OP_RUN       = 2'd2;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] weight;
    logic [DATA_W-1:0] value;
  } item_entry_t;

  typedef struct packed {
    logic              used;
    logic [DATA_W-1:0] capacity;
  } bin_entry_t;

endpackage

// ----- hdl/gbf_item_mem.sv -----
// Item store: one write port, one registered read port.
module gbf_item_mem import gbf_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [IIDX_W-1:0] waddr,
  input  item_entry_t       wdata,
  input  logic              re,
  input  logic [IIDX_W-1:0] raddr,
  output item_entry_t       rdata
);

  item_entry_t mem [MAX_ITEMS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/gbf_bin_mem.sv -----
// Bin store: capacity plus used mark, one write port, one registered read port.
module gbf_bin_mem import gbf_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [BIDX_W-1:0] waddr,
  input  bin_entry_t        wdata,
  input  logic              re,
  input  logic [BIDX_W-1:0] raddr,
  output bin_entry_t        rdata
);

  bin_entry_t mem [MAX_BINS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/greedy_best_fit_value_assignment.sv -----
// Top level: load control and the assignment sequencer around the two stores.
//
//  channel   signals                                                 handshake
//  request   start, operation, item_weight, item_value, bin_capacity start & !busy
//  result    strobe, total_value, placed_count, overflow             strobe, one cycle
//
// A run raises strobe once no unfinished item is left. Each pass walks the item store
// for the highest unfinished value, then the bin store for the best fit, one entry
// per cycle; each walk drains its outstanding reads, and a write-back state follows.
// busy is high until the result; the receiver cannot stall the block.
// Reset is synchronous; no clearing pass is needed, loads write clear marks.
module greedy_best_fit_value_assignment import gbf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic [DATA_W-1:0]  item_weight,
  input  logic [DATA_W-1:0]  item_value,
  input  logic [DATA_W-1:0]  bin_capacity,
  output logic               strobe,
  output logic [TOTAL_W-1:0] total_value,
  output logic [PLACE_W-1:0] placed_count,
  output logic               overflow
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISCAN = 3'd1;
  localparam logic [2:0] S_BSCAN = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]          state;
  logic [ICNT_W-1:0]   item_count;
  logic [BCNT_W-1:0]   bin_count;
  logic                overflow_flag;
  logic [ICNT_W-1:0]   icnt;
  logic [BCNT_W-1:0]   bcnt;
  logic                rv;
  logic [IIDX_W-1:0]   ridx;
  logic [BIDX_W-1:0]   rbidx;
  logic                found;
  logic [IIDX_W-1:0]   best_i;
  logic [DATA_W-1:0]   best_w;
  logic [DATA_W-1:0]   best_v;
  logic                bfound;
  logic [BIDX_W-1:0]   best_b;
  logic [DATA_W-1:0]   best_c;
  logic [TOTAL_W-1:0]  total;
  logic [ICNT_W-1:0]   placed;

  logic                accept;
  logic                i_we, i_re, b_we, b_re;
  logic [IIDX_W-1:0]   i_waddr;
  logic [BIDX_W-1:0]   b_waddr;
  item_entry_t         i_wdata, i_rdata;
  bin_entry_t          b_wdata, b_rdata;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  always_comb begin
    i_we    = 1'b0;
    i_waddr = item_count[IIDX_W-1:0];
    i_wdata = '{done: 1'b0, weight: item_weight, value: item_value};
    b_we    = 1'b0;
    b_waddr = bin_count[BIDX_W-1:0];
    b_wdata = '{used: 1'b0, capacity: bin_capacity};
    if (accept && operation == OP_LOAD_ITEM && item_count < ICNT_W'(MAX_ITEMS)) begin
      i_we = 1'b1;
    end
    if (accept && operation == OP_LOAD_BIN && bin_count < BCNT_W'(MAX_BINS)) begin
      b_we = 1'b1;
    end
    if (state == S_WRITE) begin
      i_we    = 1'b1;
      i_waddr = best_i;
      i_wdata = '{done: 1'b1, weight: best_w, value: best_v};
      b_we    = bfound;
      b_waddr = best_b;
      b_wdata = '{used: 1'b1, capacity: best_c};
    end
  end

  assign i_re = (state == S_ISCAN) && (icnt < item_count);
  assign b_re = (state == S_BSCAN) && (bcnt < bin_count);

  gbf_item_mem u_items (
    .clk   (clk),
    .we    (i_we),
    .waddr (i_waddr),
    .wdata (i_wdata),
    .re    (i_re),
    .raddr (icnt[IIDX_W-1:0]),
    .rdata (i_rdata)
  );

  gbf_bin_mem u_bins (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (b_re),
    .raddr (bcnt[BIDX_W-1:0]),
    .rdata (b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      item_count    <= '0;
      bin_count     <= '0;
      overflow_flag <= 1'b0;
      strobe        <= 1'b0;
      rv            <= 1'b0;
      found         <= 1'b0;
      bfound        <= 1'b0;
      icnt          <= '0;
      bcnt          <= '0;
      total         <= '0;
      placed        <= '0;
      overflow      <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (operation)
              OP_LOAD_ITEM: begin
                if (item_count < ICNT_W'(MAX_ITEMS)) item_count <= item_count + 1'b1;
                else overflow_flag <= 1'b1;
              end
              OP_LOAD_BIN: begin
                if (bin_count < BCNT_W'(MAX_BINS)) bin_count <= bin_count + 1'b1;
                else overflow_flag <= 1'b1;
              end
              OP_RUN: begin
                total  <= '0;
                placed <= '0;
                icnt   <= '0;
                found  <= 1'b0;
                rv     <= 1'b0;
                state  <= S_ISCAN;
              end
              default: ;
            endcase
          end
        end
        S_ISCAN: begin
          // highest value not yet handled; strict compare keeps load order on ties
          rv   <= i_re;
          ridx <= icnt[IIDX_W-1:0];
          if (i_re) icnt <= icnt + 1'b1;
          if (rv && !i_rdata.done && (!found || i_rdata.value > best_v)) begin
            found  <= 1'b1;
            best_i <= ridx;
            best_w <= i_rdata.weight;
            best_v <= i_rdata.value;
          end
          if (!i_re && !rv) begin
            if (found) begin
              bcnt   <= '0;
              bfound <= 1'b0;
              state  <= S_BSCAN;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_BSCAN: begin
          rv    <= b_re;
          rbidx <= bcnt[BIDX_W-1:0];
          if (b_re) bcnt <= bcnt + 1'b1;
          if (rv && !b_rdata.used && b_rdata.capacity >= best_w &&
              (!bfound || b_rdata.capacity < best_c)) begin
            bfound <= 1'b1;
            best_b <= rbidx;
            best_c <= b_rdata.capacity;
          end
          if (!b_re && !rv) state <= S_WRITE;
        end
        S_WRITE: begin
          if (bfound) begin
            total  <= total + TOTAL_W'(best_v);
            placed <= placed + 1'b1;
          end
          icnt  <= '0;
          found <= 1'b0;
          state <= S_ISCAN;
        end
        S_DONE: begin
          strobe        <= 1'b1;
          overflow      <= overflow_flag;
          item_count    <= '0;
          bin_count     <= '0;
          overflow_flag <= 1'b0;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign total_value  = total;
  assign placed_count = PLACE_W'(placed);

  a_strobe_after_done: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state) == S_DONE)
    else $error("result strobe without a finished run");

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("result strobe longer than one cycle");

  a_write_has_item: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> found)
    else $error("write-back without a selected item");

  a_scan_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_BSCAN && $past(state) == S_ISCAN) |-> !rv)
    else $error("bin scan entered with a read in flight");

endmodule
